// ===== rtl/aac_pkg.sv =====
// ----------------------------------------------------------------------------
// aac_pkg
// Shared constants, register codes and stage types for the axis calibrator.
// ----------------------------------------------------------------------------
package aac_pkg;

  localparam int ADC_BITS  = 10;
  localparam int OUT_BITS  = 10;
  localparam int TRIM_BITS = 8;
  // The scaled magnitude is always below 256, so the divider yields 8 bits.
  localparam int QUO_BITS  = 8;
  localparam int SHIFT_MAX = ADC_BITS - QUO_BITS;
  localparam int SHW       = (SHIFT_MAX > 1) ? $clog2(SHIFT_MAX + 1) : 1;
  localparam int CFG_DW    = (ADC_BITS > TRIM_BITS) ? ADC_BITS : TRIM_BITS;
  localparam int CFG_IW    = 3;

  localparam logic [ADC_BITS-1:0]        MAXCODE    = '1;
  localparam logic [ADC_BITS-1:0]        CENTER_RST = ADC_BITS'(511);
  localparam logic signed [OUT_BITS-1:0] AXIS_MAX   = OUT_BITS'(256);
  localparam logic signed [OUT_BITS-1:0] AXIS_MIN   = OUT_BITS'(-256);

  typedef enum logic [CFG_IW-1:0] {
    CFG_REVERSE = 3'd0,
    CFG_TRIM    = 3'd1,
    CFG_CENTER  = 3'd2,
    CFG_LOW     = 3'd3,
    CFG_HIGH    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic                 reverse;
    logic [TRIM_BITS-1:0] trim;
    logic [ADC_BITS-1:0]  center;
    logic [ADC_BITS-1:0]  low;
    logic [ADC_BITS-1:0]  high;
  } cfg_t;

  // Word handed from cell to cell along the divider chain.
  typedef struct packed {
    logic [ADC_BITS-1:0] rem;
    logic [ADC_BITS-1:0] span;
    logic [QUO_BITS-1:0] quo;
    logic [SHW-1:0]      shift;
    logic                neg;
    logic                sat_lo;
    logic                sat_hi;
  } div_word_t;

endpackage

// ===== rtl/aac_if.sv =====
// ----------------------------------------------------------------------------
// aac_if
// Valid/ready channels carrying raw samples in and axis values out.
// ----------------------------------------------------------------------------
interface aac_in_if;
  import aac_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface aac_out_if;
  import aac_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] axis_value;

  modport source (output valid, output axis_value, input ready);
  modport sink   (input valid, input axis_value, output ready);
endinterface

// ===== rtl/aac_front.sv =====
// ----------------------------------------------------------------------------
// aac_front
// Mirrors the sample, tests the end points, picks the side of center and
// normalizes the distance into the first word of the divider chain.
// ----------------------------------------------------------------------------
module aac_front (
  input  logic              clk,
  input  logic              rst_n,
  input  aac_pkg::cfg_t     cfg,
  aac_in_if.sink            in_ch,
  output logic              nxt_valid,
  input  logic              nxt_ready,
  output aac_pkg::div_word_t nxt_word
);
  import aac_pkg::*;

  logic                valid_r;
  div_word_t           word_r;
  div_word_t           word_nxt;
  logic [ADC_BITS-1:0] s_mir;
  logic [ADC_BITS-1:0] delta;
  logic [ADC_BITS-1:0] span;
  logic [SHW-1:0]      sh;
  logic [QUO_BITS-1:0] delta_n;

  assign in_ch.ready = !valid_r || nxt_ready;

  always_comb begin
    s_mir = cfg.reverse ? (MAXCODE - in_ch.sample) : in_ch.sample;
    if (s_mir > cfg.center) begin
      delta = s_mir - cfg.center;
      span  = cfg.high - cfg.center;
    end else begin
      delta = cfg.center - s_mir;
      span  = cfg.center - cfg.low;
    end
    // Smallest right shift that brings the distance below 256.
    sh = '0;
    for (int k = SHIFT_MAX; k >= 0; k--) begin
      if ((delta >> k) < (1 << QUO_BITS)) begin
        sh = SHW'(k);
      end
    end
    delta_n = QUO_BITS'(delta >> sh);

    word_nxt.rem    = {{(ADC_BITS-QUO_BITS){1'b0}}, delta_n};
    word_nxt.span   = span;
    word_nxt.quo    = '0;
    word_nxt.shift  = sh;
    word_nxt.neg    = s_mir < cfg.center;
    word_nxt.sat_lo = s_mir <= cfg.low;
    word_nxt.sat_hi = s_mir >= cfg.high;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      word_r <= word_nxt;
    end
  end

  assign nxt_valid = valid_r;
  assign nxt_word  = word_r;

endmodule

// ===== rtl/aac_div_cell.sv =====
// ----------------------------------------------------------------------------
// aac_div_cell
// One restoring division step: doubles the remainder, subtracts the span when
// it fits and shifts one quotient bit in.
// ----------------------------------------------------------------------------
module aac_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               prv_valid,
  output logic               prv_ready,
  input  aac_pkg::div_word_t prv_word,
  output logic               nxt_valid,
  input  logic               nxt_ready,
  output aac_pkg::div_word_t nxt_word
);
  import aac_pkg::*;

  logic                valid_r;
  div_word_t           word_r;
  div_word_t           word_nxt;
  logic [ADC_BITS:0]   rem2;
  logic [ADC_BITS:0]   diff;
  logic                fits;

  assign prv_ready = !valid_r || nxt_ready;

  always_comb begin
    rem2     = {prv_word.rem, 1'b0};
    diff     = rem2 - {1'b0, prv_word.span};
    fits     = rem2 >= {1'b0, prv_word.span};
    word_nxt = prv_word;
    word_nxt.rem = fits ? diff[ADC_BITS-1:0] : rem2[ADC_BITS-1:0];
    word_nxt.quo = {prv_word.quo[QUO_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (prv_ready) begin
      valid_r <= prv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prv_ready && prv_valid) begin
      word_r <= word_nxt;
    end
  end

  assign nxt_valid = valid_r;
  assign nxt_word  = word_r;

endmodule

// ===== rtl/aac_back.sv =====
// ----------------------------------------------------------------------------
// aac_back
// Undoes the normalizing shift, applies sign and trim, saturates and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module aac_back (
  input  logic               clk,
  input  logic               rst_n,
  input  aac_pkg::cfg_t      cfg,
  input  logic               prv_valid,
  output logic               prv_ready,
  input  aac_pkg::div_word_t prv_word,
  aac_out_if.source          out_ch
);
  import aac_pkg::*;

  logic                       valid_r;
  logic signed [OUT_BITS-1:0] axis_r;
  logic signed [OUT_BITS-1:0] axis_nxt;
  logic [QUO_BITS-1:0]        mag;
  logic signed [OUT_BITS-1:0] mag_x;
  logic signed [OUT_BITS-1:0] trim_x;
  logic signed [OUT_BITS-1:0] sum;

  assign prv_ready = !valid_r || out_ch.ready;

  always_comb begin
    // The shifted-back magnitude stays below 256 for every unsaturated sample.
    mag    = prv_word.quo << prv_word.shift;
    mag_x  = {{(OUT_BITS-QUO_BITS){1'b0}}, mag};
    trim_x = {{(OUT_BITS-TRIM_BITS){cfg.trim[TRIM_BITS-1]}}, cfg.trim};
    sum    = (prv_word.neg ? -mag_x : mag_x) + trim_x;
    if (prv_word.sat_lo) begin
      axis_nxt = AXIS_MIN;
    end else if (prv_word.sat_hi) begin
      axis_nxt = AXIS_MAX;
    end else if (sum <= AXIS_MIN) begin
      axis_nxt = AXIS_MIN;
    end else if (sum >= AXIS_MAX) begin
      axis_nxt = AXIS_MAX;
    end else begin
      axis_nxt = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (prv_ready) begin
      valid_r <= prv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prv_ready && prv_valid) begin
      axis_r <= axis_nxt;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.axis_value = axis_r;

endmodule

// ===== rtl/analog_axis_calibrate.sv =====
// ----------------------------------------------------------------------------
// analog_axis_calibrate
// Three-point axis calibration: raw converter samples in, signed axis out.
// ----------------------------------------------------------------------------
// Usage: words enter on in_ch (valid/ready, field sample) and leave on
// out_ch (valid/ready, field axis_value in -256..256, two's complement).
// The calibration registers are written through cfg_we/cfg_idx/cfg_data;
// index 0 reverse, 1 trim, 2 center, 3 low, 4 high. Write them only while
// no word is in flight.
// From acceptance to the result being offered a word passes one front stage,
// eight division cells (one quotient bit each) and the output register. The
// divider chain is fully pipelined, so one word is taken every cycle while the
// receiver keeps out_ch.ready high.
// Reset clears every stage's valid flag and loads the default calibration
// (center 511, low 0, high 1023, no trim, no reversal).
// When the receiver stalls, words pile up in the chain until each stage
// holds one; in_ch.ready falls only then, and nothing is dropped.
// ----------------------------------------------------------------------------
module analog_axis_calibrate (
  input  logic                       clk,
  input  logic                       rst_n,
  aac_in_if.sink                     in_ch,
  aac_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [aac_pkg::CFG_IW-1:0] cfg_idx,
  input  logic [aac_pkg::CFG_DW-1:0] cfg_data
);
  import aac_pkg::*;

  cfg_t      cfg_r;
  logic      stage_valid [QUO_BITS+1];
  logic      stage_ready [QUO_BITS+1];
  div_word_t stage_word  [QUO_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reverse <= 1'b0;
      cfg_r.trim    <= '0;
      cfg_r.center  <= CENTER_RST;
      cfg_r.low     <= '0;
      cfg_r.high    <= MAXCODE;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_REVERSE: cfg_r.reverse <= cfg_data[0];
        CFG_TRIM:    cfg_r.trim    <= cfg_data[TRIM_BITS-1:0];
        CFG_CENTER:  cfg_r.center  <= cfg_data[ADC_BITS-1:0];
        CFG_LOW:     cfg_r.low     <= cfg_data[ADC_BITS-1:0];
        CFG_HIGH:    cfg_r.high    <= cfg_data[ADC_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  aac_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .nxt_valid (stage_valid[0]),
    .nxt_ready (stage_ready[0]),
    .nxt_word  (stage_word[0])
  );

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
    aac_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .prv_valid (stage_valid[i]),
      .prv_ready (stage_ready[i]),
      .prv_word  (stage_word[i]),
      .nxt_valid (stage_valid[i+1]),
      .nxt_ready (stage_ready[i+1]),
      .nxt_word  (stage_word[i+1])
    );
  end

  aac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .prv_valid (stage_valid[QUO_BITS]),
    .prv_ready (stage_ready[QUO_BITS]),
    .prv_word  (stage_word[QUO_BITS]),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // A receiver that is ready lets the whole chain move, so the input is open.
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input blocked while the receiver is ready");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.axis_value >= AXIS_MIN && out_ch.axis_value <= AXIS_MAX))
    else $error("axis value outside the saturation limits");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result offered right after reset");
`endif

endmodule

// ===== tb/aac_axis_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_axis_checker
// Watches both channels of the axis calibrator, keeps its own copy of the
// calibration registers, predicts the axis value of every accepted sample
// and compares each delivered word against the oldest prediction.
// ----------------------------------------------------------------------------
module aac_axis_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  aac_in_if                          in_ch,
  aac_out_if                         out_ch,
  input  logic                       cfg_we,
  input  logic [aac_pkg::CFG_IW-1:0] cfg_idx,
  input  logic [aac_pkg::CFG_DW-1:0] cfg_data,
  output int                         errors,
  output int                         pending
);
  import aac_pkg::*;

  cfg_t                       cal;
  logic signed [OUT_BITS-1:0] axis_expect_q[$];
  int                         err_count;

  function automatic logic signed [OUT_BITS-1:0] calibrate_axis(
    logic [ADC_BITS-1:0] raw
  );
    int s, delta, span, q, v, sh;
    sh = 0;
    s  = cal.reverse ? int'(MAXCODE) - int'(raw) : int'(raw);
    if (s <= int'(cal.low)) return AXIS_MIN;
    if (s >= int'(cal.high)) return AXIS_MAX;
    if (s > int'(cal.center)) begin
      delta = s - int'(cal.center);
      span  = int'(cal.high) - int'(cal.center);
    end else begin
      delta = int'(cal.center) - s;
      span  = int'(cal.center) - int'(cal.low);
    end
    // Bring the distance under 256 before the divide, then undo the shift.
    while (delta >= 256) begin
      delta = delta >> 1;
      sh++;
    end
    q = (span != 0) ? (delta << 8) / span : 0;
    q = (q << sh) & 'hFFFF;
    v = (s < int'(cal.center)) ? -q : q;
    v = v + int'($signed(cal.trim));
    if (v <= int'(AXIS_MIN)) return AXIS_MIN;
    if (v >= int'(AXIS_MAX)) return AXIS_MAX;
    return OUT_BITS'(v);
  endfunction

  always @(posedge clk) begin
    logic signed [OUT_BITS-1:0] want;
    if (!rst_n) begin
      cal.reverse = 1'b0;
      cal.trim    = '0;
      cal.center  = CENTER_RST;
      cal.low     = '0;
      cal.high    = MAXCODE;
      err_count   = 0;
      axis_expect_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_REVERSE: cal.reverse = cfg_data[0];
          CFG_TRIM:    cal.trim    = cfg_data[TRIM_BITS-1:0];
          CFG_CENTER:  cal.center  = cfg_data[ADC_BITS-1:0];
          CFG_LOW:     cal.low     = cfg_data[ADC_BITS-1:0];
          CFG_HIGH:    cal.high    = cfg_data[ADC_BITS-1:0];
          default:     ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        axis_expect_q.push_back(calibrate_axis(in_ch.sample));
      if (out_ch.valid && out_ch.ready) begin
        if (axis_expect_q.size() == 0) begin
          $error("axis_value: no word expected, got %0d", out_ch.axis_value);
          err_count++;
        end else begin
          want = axis_expect_q.pop_front();
          if (out_ch.axis_value !== want) begin
            $error("axis_value mismatch: expected %0d, got %0d", want, out_ch.axis_value);
            err_count++;
          end
        end
      end
    end
    errors  <= err_count;
    pending <= axis_expect_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the axis calibrator with directed corner samples and with random
// calibration setups followed by bursts of random samples, while the output
// side stalls in changing patterns. The checker does all the comparing.
// ----------------------------------------------------------------------------
module testbench;
  import aac_pkg::*;

  localparam int LATENCY     = 10;
  localparam int IDLE_LIMIT  = 1000;
  localparam int PHASE_WORDS = 48;
  localparam int NUM_PHASES  = 10;

  localparam logic [CFG_IW-1:0] IDX_SPARE_LO = CFG_HIGH + 1'b1;
  localparam logic [CFG_IW-1:0] IDX_SPARE_HI = '1;

  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_LONG} rx_mode_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_data;
  int                errors;
  int                pending;

  // The stimulus side's own view of the calibration, used to aim samples.
  int cur_rev, cur_center, cur_low, cur_high;

  rx_mode_t rx_mode  = RX_OPEN;
  int       rx_cycle = 0;
  int       rx_hold  = 0;
  int       idle_cnt = 0;

  aac_in_if  in_ch ();
  aac_out_if out_ch ();

  analog_axis_calibrate dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  aac_axis_checker checker_i (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: drives out_ch.ready in one of four stall patterns, redrawn at random.
  always @(negedge clk) begin
    if (rx_cycle % 64 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    rx_cycle++;
    case (rx_mode)
      RX_OPEN:     out_ch.ready <= 1'b1;
      RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_ch.ready <= (rx_cycle % 7) < 3;
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          out_ch.ready <= 1'b0;
        end else begin
          rx_hold = $urandom_range(0, 20);
          out_ch.ready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  task automatic push_word(int s);
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.sample <= ADC_BITS'(s);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic pause(int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid  <= 1'b0;
      in_ch.sample <= ADC_BITS'($urandom);
    end
  endtask

  // Hold the sender until every predicted word has come out.
  task automatic settle();
    pause(1);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, int data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DW'(data);
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic apply_setup(int rev, int trim, int center, int low, int high);
    logic [TRIM_BITS-1:0] trim_bits;
    trim_bits = TRIM_BITS'(trim);
    write_reg(CFG_REVERSE, rev);
    write_reg(CFG_TRIM, int'(trim_bits));
    write_reg(CFG_CENTER, center);
    write_reg(CFG_LOW, low);
    write_reg(CFG_HIGH, high);
    cur_rev    = rev;
    cur_center = center;
    cur_low    = low;
    cur_high   = high;
  endtask

  task automatic random_setup();
    int rev, trim, center, low, high, pick;
    rev = $urandom_range(0, 1);
    case ($urandom_range(0, 3))
      0:       trim = -128;
      1:       trim = 127;
      2:       trim = 0;
      default: trim = $urandom_range(0, 255) - 128;
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      low    = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 400);
      high   = ($urandom_range(0, 4) == 0) ? int'(MAXCODE) : $urandom_range(600, 1023);
      center = $urandom_range(low, high);
    end else if (pick < 8) begin
      low    = $urandom_range(0, 1023);
      high   = $urandom_range(0, 1023);
      center = $urandom_range(0, 1023);
    end else if (pick == 8) begin
      low    = 0;
      high   = int'(MAXCODE);
      center = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 2) == 1 ? 1023
             : $urandom_range(0, 1023);
    end else begin
      // Very narrow spans on both sides of center.
      center = $urandom_range(10, 1013);
      low    = center - $urandom_range(1, 3);
      high   = center + $urandom_range(1, 3);
    end
    apply_setup(rev, trim, center, low, high);
  endtask

  function automatic int near_point(int base);
    int t;
    t = base + $urandom_range(0, 4) - 2;
    if (t < 0) t = 0;
    if (t > int'(MAXCODE)) t = int'(MAXCODE);
    return cur_rev ? int'(MAXCODE) - t : t;
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(0, 9))
      6:       return near_point(cur_low);
      7:       return near_point(cur_high);
      8:       return near_point(cur_center);
      9:       return $urandom_range(0, 1) ? 0 : int'(MAXCODE);
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  initial begin
    int left, burst;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    cur_rev      = 0;
    cur_center   = int'(CENTER_RST);
    cur_low      = 0;
    cur_high     = int'(MAXCODE);
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Writes to unused indexes must leave the reset calibration alone.
    write_reg(IDX_SPARE_LO, 'h155);
    write_reg(IDX_SPARE_HI, 'h2AA);
    push_word(0);
    push_word(1023);
    push_word(511);
    push_word(512);
    push_word(510);
    push_word(1022);
    push_word(1);
    push_word('h2AA);
    push_word('h155);
    settle();

    // Mirrored samples landing on low, high and center; most negative trim.
    apply_setup(1, -128, 300, 50, 900);
    push_word(973);
    push_word(123);
    push_word(723);
    push_word(1023);
    push_word(0);
    settle();

    // Center at the bottom end, largest trim.
    apply_setup(0, 127, 0, 0, 1023);
    push_word(1);
    push_word(1022);
    push_word(0);
    settle();

    // Calibration points out of order: the low test wins.
    apply_setup(0, 0, 1023, 800, 200);
    push_word(800);
    push_word(801);
    push_word(100);
    settle();

    // Low, center and high all the same.
    apply_setup(0, 0, 500, 500, 500);
    push_word(500);
    push_word(501);
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      random_setup();
      left = PHASE_WORDS;
      while (left > 0) begin
        burst = $urandom_range(1, 16);
        if (burst > left) burst = left;
        repeat (burst) begin
          push_word(pick_sample());
          left--;
        end
        if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
      end
      settle();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/aac_pkg.sv
rtl/aac_if.sv
rtl/aac_front.sv
rtl/aac_div_cell.sv
rtl/aac_back.sv
rtl/analog_axis_calibrate.sv
tb/aac_axis_checker.sv
tb/testbench.sv
